>>> design/iapsp_pkg.sv
// Package for the incremental all-pairs shortest-distance block.
// Holds sizes, codes, shared types and the saturating distance add.
// Depends on nothing; the relaxation and top-level files use it by scoped names.
package iapsp_pkg;

	localparam int MAX_NODES = 255;
	localparam int DIST_BITS = 48;
	localparam int SUM_BITS  = 64;
	localparam int IDX_BITS  = $clog2(MAX_NODES + 1);
	localparam int ADDR_BITS = 2 * IDX_BITS;
	localparam int ROW_DEPTH = 1 << IDX_BITS;
	localparam int MAT_DEPTH = 1 << ADDR_BITS;
	// compare width wide enough for port node numbers and internal indexes
	localparam int CMP_BITS  = (IDX_BITS > 8) ? IDX_BITS : 8;

	typedef logic [DIST_BITS-1:0] dist_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [SUM_BITS-1:0]  sum_t;
	typedef logic [CMP_BITS-1:0]  cmp_t;

	localparam dist_t DIST_INF = {DIST_BITS{1'b1}};
	localparam sum_t  SUM_MAX  = {SUM_BITS{1'b1}};
	localparam logic [7:0] NODE_COUNT_RST = 8'd255;

	// request codes
	localparam logic [1:0] REQ_ROAD    = 2'd0;
	localparam logic [1:0] REQ_AIRPORT = 2'd1;
	localparam logic [1:0] REQ_QUERY   = 2'd2;

	// configuration register indexes
	localparam logic CFG_NODE_COUNT   = 1'b0;
	localparam logic CFG_AIRPORT_COST = 1'b1;

	// one relaxation pair entering the pipeline
	typedef struct packed {
		logic  valid;
		logic  sum_en;
		addr_t addr;
	} pair_issue_t;

	// matrix write from the relaxation pipeline
	typedef struct packed {
		logic  en;
		addr_t addr;
		dist_t data;
	} mat_write_t;

	// saturating add; all ones means unreachable
	function automatic dist_t sat_add(input dist_t a, input dist_t b);
		logic [DIST_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (a == DIST_INF || b == DIST_INF || s[DIST_BITS])
			return DIST_INF;
		return s[DIST_BITS-1:0];
	endfunction

	// lower-triangle address of an unordered pair
	function automatic addr_t tri_addr(input idx_t x, input idx_t y);
		if (x > y)
			return {x, y};
		return {y, x};
	endfunction

endpackage

>>> design/iapsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module iapsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/iapsp_relax.sv
// Relaxation pipeline: path candidates through the new edge, matrix
// write-back and the running pair sum. Depends on iapsp_pkg.
module iapsp_relax (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iapsp_pkg::pair_issue_t issue,
	input  iapsp_pkg::dist_t      ra_i,
	input  iapsp_pkg::dist_t      rb_i,
	input  iapsp_pkg::dist_t      ra_j,
	input  iapsp_pkg::dist_t      rb_j,
	input  iapsp_pkg::dist_t      mat_rdata,
	input  iapsp_pkg::dist_t      edge_w,
	output iapsp_pkg::mat_write_t wr,
	output logic                  busy,
	output iapsp_pkg::sum_t       pair_sum
);

	logic                v_s1, v_s2, v_s3;
	logic                se_s1, se_s2, se_s3;
	iapsp_pkg::addr_t    addr_s1, addr_s2, addr_s3;
	iapsp_pkg::dist_t    p1_s2, p2_s2, old_s2, cand_s3, old_s3;
	iapsp_pkg::dist_t    p1, p2, pmin, cand, diff;
	iapsp_pkg::sum_t     sum_q, sum_d;
	logic [iapsp_pkg::SUM_BITS:0] add_w;
	logic                upd;

	// candidates from the snapshotted rows
	assign p1   = iapsp_pkg::sat_add(ra_i, rb_j);
	assign p2   = iapsp_pkg::sat_add(rb_i, ra_j);
	assign pmin = (p1_s2 < p2_s2) ? p1_s2 : p2_s2;
	assign cand = iapsp_pkg::sat_add(pmin, edge_w);

	assign upd  = v_s3 && (cand_s3 < old_s3);
	assign diff = old_s3 - cand_s3;
	assign add_w = {1'b0, sum_q} + {{(iapsp_pkg::SUM_BITS + 1 - iapsp_pkg::DIST_BITS){1'b0}},
		cand_s3};

	// adjust the sum for a shortened pair
	always_comb begin
		sum_d = sum_q;
		if (upd && se_s3) begin
			if (old_s3 != iapsp_pkg::DIST_INF) begin
				if (sum_q != iapsp_pkg::SUM_MAX) begin
					if (iapsp_pkg::sum_t'(diff) > sum_q)
						sum_d = '0;
					else
						sum_d = sum_q - iapsp_pkg::sum_t'(diff);
				end
			end else begin
				sum_d = add_w[iapsp_pkg::SUM_BITS] ? iapsp_pkg::SUM_MAX
					: add_w[iapsp_pkg::SUM_BITS-1:0];
			end
		end
	end

	// advance the pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			sum_q <= '0;
		end else begin
			v_s1  <= issue.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			sum_q <= sum_d;
		end
	end

	// advance the pipeline payload
	always_ff @(posedge clk) begin
		addr_s1 <= issue.addr;
		se_s1   <= issue.sum_en;
		addr_s2 <= addr_s1;
		se_s2   <= se_s1;
		p1_s2   <= p1;
		p2_s2   <= p2;
		old_s2  <= mat_rdata;
		addr_s3 <= addr_s2;
		se_s3   <= se_s2;
		cand_s3 <= cand;
		old_s3  <= old_s2;
	end

	assign wr.en    = upd;
	assign wr.addr  = addr_s3;
	assign wr.data  = cand_s3;
	assign busy     = v_s1 | v_s2 | v_s3;
	assign pair_sum = sum_q;

endmodule

>>> design/incremental_apsp_sum.sv
// Incremental all-pairs shortest-distance keeper with a running pair sum.
// Depends on iapsp_pkg, iapsp_ram and iapsp_relax.
//
// After reset the block sweeps the distance memory (one entry a cycle)
// before it takes its first word; configuration writes are taken during
// the sweep. A query gives one word. A road or airport request that changes
// the matrix first snapshots the two rows, then relaxes every pair, one
// matrix read-modify-write per cycle within a row through the single read
// port, and then drains the pipeline. A request that is out of range, brings
// no gain or repeats an airport finishes without writing the matrix.
module incremental_apsp_sum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  node_a,
	input  logic [7:0]  node_b,
	input  logic [31:0] weight,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] total_distance
);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK, ST_CHKW, ST_SNAPA, ST_SNAPB,
		ST_SWAIT, ST_ROWI, ST_PAIR, ST_DRAIN
	} state_t;

	state_t                 state_q;
	iapsp_pkg::addr_t       clr_q;
	logic [7:0]             node_count_q;
	logic [31:0]            airport_cost_q;
	iapsp_pkg::idx_t        a_q, b_q, k_q, i_q, j_q, n_q;
	iapsp_pkg::dist_t       w_q, rai_q, rbi_q;
	logic                   out_valid_q;
	iapsp_pkg::sum_t        out_q;
	logic                   snap_v_s1, snap_b_s1, snap_diag_s1;
	iapsp_pkg::idx_t        snap_k_s1;
	logic                   diag_q;
	logic                   apt_q;

	iapsp_pkg::cmp_t        n_eff, a_c, b_c;
	iapsp_pkg::idx_t        a_i, b_i;
	logic                   accept, a_ok, b_ok;
	iapsp_pkg::addr_t       m_raddr, m_waddr;
	iapsp_pkg::dist_t       m_rdata, m_wdata, ra_rdata, rb_rdata, snap_data;
	logic                   m_we;
	logic                   mark_we;
	iapsp_pkg::idx_t        row_raddr;
	iapsp_pkg::pair_issue_t issue;
	iapsp_pkg::mat_write_t  rwr;
	logic                   busy;
	iapsp_pkg::sum_t        pair_sum;

	// effective node count and range checks
	assign n_eff = (iapsp_pkg::cmp_t'(node_count_q) > iapsp_pkg::cmp_t'(iapsp_pkg::MAX_NODES))
		? iapsp_pkg::cmp_t'(iapsp_pkg::MAX_NODES) : iapsp_pkg::cmp_t'(node_count_q);
	assign a_c  = iapsp_pkg::cmp_t'(node_a);
	assign b_c  = iapsp_pkg::cmp_t'(node_b);
	assign a_ok = (a_c != '0) && (a_c <= n_eff);
	assign b_ok = (b_c != '0) && (b_c <= n_eff);
	assign a_i  = iapsp_pkg::idx_t'(node_a);
	assign b_i  = iapsp_pkg::idx_t'(node_b);

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// matrix read address by phase
	always_comb begin
		unique case (state_q)
			ST_CHECK: m_raddr = iapsp_pkg::tri_addr(a_q, b_q);
			ST_SNAPA: m_raddr = iapsp_pkg::tri_addr(a_q, k_q);
			ST_SNAPB: m_raddr = iapsp_pkg::tri_addr(b_q, k_q);
			default:  m_raddr = {i_q, j_q};
		endcase
	end

	assign row_raddr = (state_q == ST_PAIR) ? j_q : i_q;

	// airport marks live on the unused diagonal: all ones is unmarked, zero is marked
	assign mark_we = (state_q == ST_CHKW) && apt_q && (m_rdata == iapsp_pkg::DIST_INF);

	// matrix write: sweep after reset, airport mark, then relaxation results
	always_comb begin
		if (state_q == ST_CLEAR) begin
			m_we    = 1'b1;
			m_waddr = clr_q;
			m_wdata = iapsp_pkg::DIST_INF;
		end else if (mark_we) begin
			m_we    = 1'b1;
			m_waddr = {b_q, b_q};
			m_wdata = '0;
		end else begin
			m_we    = rwr.en;
			m_waddr = rwr.addr;
			m_wdata = rwr.data;
		end
	end

	assign snap_data = snap_diag_s1 ? '0 : m_rdata;

	assign issue.valid  = (state_q == ST_PAIR);
	assign issue.sum_en = (j_q != '0);
	assign issue.addr   = {i_q, j_q};

	iapsp_ram #(.WIDTH(iapsp_pkg::DIST_BITS), .DEPTH(iapsp_pkg::MAT_DEPTH)) u_mat (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	iapsp_ram #(.WIDTH(iapsp_pkg::DIST_BITS), .DEPTH(iapsp_pkg::ROW_DEPTH)) u_row_a (
		.clk   (clk),
		.we    (snap_v_s1 && !snap_b_s1),
		.waddr (snap_k_s1),
		.wdata (snap_data),
		.raddr (row_raddr),
		.rdata (ra_rdata)
	);

	iapsp_ram #(.WIDTH(iapsp_pkg::DIST_BITS), .DEPTH(iapsp_pkg::ROW_DEPTH)) u_row_b (
		.clk   (clk),
		.we    (snap_v_s1 && snap_b_s1),
		.waddr (snap_k_s1),
		.wdata (snap_data),
		.raddr (row_raddr),
		.rdata (rb_rdata)
	);

	iapsp_relax u_relax (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.ra_i      (rai_q),
		.rb_i      (rbi_q),
		.ra_j      (ra_rdata),
		.rb_j      (rb_rdata),
		.mat_rdata (m_rdata),
		.edge_w    (w_q),
		.wr        (rwr),
		.busy      (busy),
		.pair_sum  (pair_sum)
	);

	// snapshot write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_s1 <= 1'b0;
		end else begin
			snap_v_s1 <= (state_q == ST_SNAPA) || (state_q == ST_SNAPB);
		end
	end

	always_ff @(posedge clk) begin
		snap_b_s1    <= (state_q == ST_SNAPB);
		snap_k_s1    <= k_q;
		snap_diag_s1 <= (state_q == ST_SNAPA) ? (k_q == a_q) : (k_q == b_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q   <= iapsp_pkg::NODE_COUNT_RST;
			airport_cost_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iapsp_pkg::CFG_NODE_COUNT:   node_count_q   <= cfg_data[7:0];
				iapsp_pkg::CFG_AIRPORT_COST: airport_cost_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: sweep, accept, check, snapshot, relax, drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			a_q <= '0; b_q <= '0; k_q <= '0; i_q <= '0; j_q <= '0; n_q <= '0;
			w_q <= '0; rai_q <= '0; rbi_q <= '0; out_q <= '0; diag_q <= 1'b0;
			apt_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						n_q <= iapsp_pkg::idx_t'(n_eff);
						unique case (req_type)
							iapsp_pkg::REQ_ROAD: begin
								a_q    <= a_i;
								b_q    <= b_i;
								apt_q  <= 1'b0;
								diag_q <= (a_i == b_i);
								w_q    <= iapsp_pkg::dist_t'({weight, 1'b0});
								if (a_ok && b_ok)
									state_q <= ST_CHECK;
							end
							iapsp_pkg::REQ_AIRPORT: begin
								// read the node's mark first
								if (a_ok) begin
									a_q     <= a_i;
									b_q     <= a_i;
									apt_q   <= 1'b1;
									w_q     <= iapsp_pkg::dist_t'(airport_cost_q);
									state_q <= ST_CHECK;
								end
							end
							iapsp_pkg::REQ_QUERY: begin
								out_q       <= pair_sum;
								out_valid_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_CHECK: state_q <= ST_CHKW;
				ST_CHKW: begin
					k_q <= '0;
					if (apt_q) begin
						// unmarked airport: mark it and insert the hub edge
						if (m_rdata == iapsp_pkg::DIST_INF) begin
							a_q     <= '0;
							state_q <= ST_SNAPA;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (!diag_q && (w_q < m_rdata)) begin
						state_q <= ST_SNAPA;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SNAPA: begin
					k_q <= k_q + 1'b1;
					if (k_q == n_q) begin
						k_q     <= '0;
						state_q <= ST_SNAPB;
					end
				end
				ST_SNAPB: begin
					k_q <= k_q + 1'b1;
					if (k_q == n_q) begin
						i_q     <= iapsp_pkg::idx_t'(1);
						state_q <= ST_SWAIT;
					end
				end
				ST_SWAIT: state_q <= ST_ROWI;
				ST_ROWI: begin
					j_q     <= '0;
					state_q <= ST_PAIR;
				end
				ST_PAIR: begin
					if (j_q == '0) begin
						rai_q <= ra_rdata;
						rbi_q <= rb_rdata;
					end
					j_q <= j_q + 1'b1;
					if (j_q == i_q - 1'b1) begin
						if (i_q == n_q) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_ROWI;
						end
					end
				end
				ST_DRAIN: begin
					if (!busy)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign total_distance = out_q;

endmodule
